/* sv/rotating_arm_chain_plotter_assert.svh */
// Assertion shorthands for the arm chain plotter.
`ifndef ROTATING_ARM_CHAIN_PLOTTER_ASSERT_SVH
`define ROTATING_ARM_CHAIN_PLOTTER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define RACP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define RACP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/racp_pkg.sv */
`default_nettype none

package racp_pkg;

    localparam int PHASE_W = 16;

    typedef logic [PHASE_W-1:0] phase_t;     // one turn = 2^16
    typedef logic signed [16:0] sine_t;      // Q15, -32768..32768

    localparam phase_t QUARTER_TURN = 16'h4000;

    typedef logic [2:0] reg_index_t;

    localparam reg_index_t REG_ARM_COUNT   = 3'd0;
    localparam reg_index_t REG_CENTER_X    = 3'd1;
    localparam reg_index_t REG_CENTER_Y    = 3'd2;
    localparam reg_index_t REG_ARM_LENGTHS = 3'd3;
    localparam reg_index_t REG_ARM_SPEEDS  = 3'd4;

endpackage

`default_nettype wire

/* sv/racp_sine.sv */
`default_nettype none

// Quarter-wave sine lookup with a registered table read.
module racp_sine
    import racp_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256
)
(
    input  wire         clk,
    input  wire phase_t phase,
    output sine_t       sine
);

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SCL_W = 14 + IDX_W;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210};

    // sin(pi/2 * k / depth) in Q15, Taylor series in Q30
    function automatic logic [15:0] table_entry(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x    = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
        term = x;
        sum  = signed'(x);
        for (int n = 0; n < 7; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TAYLOR_DIV[n];
            if (!n[0])
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = '0;
        v = (64'(sum) + 64'd16384) >> 15;
        if (v > 64'd32768)
            v = 64'd32768;
        return v[15:0];
    endfunction

    logic [15:0] rom [SINE_TABLE_DEPTH+1];

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++)
    begin : g_rom
        assign rom[k] = table_entry(k);
    end

    logic [SCL_W-1:0] scaled;
    logic [IDX_W-1:0] tab_idx;
    logic [IDX_W-1:0] rom_addr;
    logic [15:0]      rom_q_reg;
    logic             neg_reg;
    sine_t            mag;

    // index = p * depth / 2^14, mirrored in odd quadrants
    assign scaled   = SCL_W'(phase[13:0]) * SCL_W'(SINE_TABLE_DEPTH);
    assign tab_idx  = scaled[14 +: IDX_W];
    assign rom_addr = phase[14] ? IDX_W'(SINE_TABLE_DEPTH) - tab_idx : tab_idx;

    always_ff @(posedge clk)
    begin
        rom_q_reg <= rom[rom_addr];
        neg_reg   <= phase[15];
    end

    assign mag  = sine_t'({1'b0, rom_q_reg});
    assign sine = neg_reg ? -mag : mag;

endmodule

`default_nettype wire

/* sv/rotating_arm_chain_plotter.sv */
`default_nettype none
`include "rotating_arm_chain_plotter_assert.svh"

// Rotating arm chain plotter. Each input transfer carries elapsed_time; for every
// active arm (arm_count, 0 treated as 1, clipped to ARMS) the 16-bit phase
// accumulator advances by floor(speed * elapsed_time / 2^16), wrapping at one
// turn, and the pen is reported as pen_x = center_x + sum L*sin(phase),
// pen_y = center_y - sum L*cos(phase), each sum rounded half up to whole pixels.
// Phase 0 points up and y grows downward. Inactive arms keep their phase.
// Timing: IDLE takes the transfer, each active arm then passes through PHASE,
// COS, ACCX and ACCY, and FIN loads the output register once any earlier
// result has been taken. The step sequence follows from the single
// shared 17x17 multiplier, used three times per arm (step, L*sin, L*cos), and
// the single-port sine table, read twice per arm. The block stalls its input
// while working; a finished result sits in the output register and the next
// transfer is taken while it waits. Configuration is written through the plain
// write port with no read-back; writes to indexes above 4 are dropped.
module rotating_arm_chain_plotter
    import racp_pkg::*;
#(
    parameter int ARMS             = 4,
    parameter int SINE_TABLE_DEPTH = 256
)
(
    input  wire                clk,
    input  wire                rst_n,

    // configuration write port
    input  wire                cfg_write,
    input  wire  [2:0]         cfg_index,
    input  wire  [63:0]        cfg_data,

    // tick input
    input  wire                in_valid,
    output logic               in_stall,
    input  wire  [15:0]        elapsed_time,

    // pen output
    output logic               out_valid,
    input  wire                out_stall,
    output logic signed [12:0] pen_x,
    output logic signed [12:0] pen_y
);

    localparam int         ARM_W     = (ARMS > 1) ? $clog2(ARMS) : 1;
    localparam logic [2:0] COUNT_MAX = 3'(ARMS);

    // IDLE takes a transfer and forms arm 0's step; per arm:
    // PHASE  update phase, look up sin
    // COS    L*sin, look up cos
    // ACCX   add L*sin, L*cos
    // ACCY   add L*cos, next arm's step
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE,
        ST_COS,
        ST_ACCX,
        ST_ACCY,
        ST_FIN
    } state_t;

    // configuration
    logic [2:0]  arm_count_reg;
    logic [9:0]  center_x_reg;
    logic [9:0]  center_y_reg;
    logic [35:0] arm_lengths_reg;
    logic [63:0] arm_speeds_reg;

    // sequencer
    state_t             state_reg,   state_next;
    logic [ARM_W-1:0]   arm_idx_reg, arm_idx_next;
    logic [15:0]        t_reg,       t_next;
    logic signed [27:0] acc_x_reg,   acc_x_next;
    logic signed [27:0] acc_y_reg,   acc_y_next;
    logic               out_valid_reg, out_valid_next;
    logic [12:0]        pen_x_reg,   pen_x_next;
    logic [12:0]        pen_y_reg,   pen_y_next;

    phase_t             phase_reg [ARMS];
    logic signed [33:0] prod_reg;

    logic [2:0]         n_eff;
    logic               last_arm;
    logic [ARM_W-1:0]   spd_idx;
    logic [15:0]        speed_sel;
    logic [5:0]         len_base;
    logic [8:0]         len_sel;
    logic [15:0]        time_sel;
    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [33:0] mul_p;
    phase_t             ph_new;
    phase_t             sine_phase;
    sine_t              sine_val;
    logic signed [27:0] round_x;
    logic signed [27:0] round_y;

    // arms in use: zero acts as one, clipped to ARMS
    always_comb
    begin
        if (arm_count_reg == 3'd0)
            n_eff = 3'd1;
        else if (arm_count_reg > COUNT_MAX)
            n_eff = COUNT_MAX;
        else
            n_eff = arm_count_reg;
    end

    assign last_arm = (3'(arm_idx_reg) == n_eff - 3'd1);

    // operand selection for the shared multiplier
    assign spd_idx   = (state_reg == ST_IDLE) ? '0 : arm_idx_reg + ARM_W'(1);
    assign speed_sel = arm_speeds_reg[{spd_idx, 4'b0000} +: 16];
    assign len_base  = 6'(arm_idx_reg) * 6'd9;
    assign len_sel   = arm_lengths_reg[len_base +: 9];
    assign time_sel  = (state_reg == ST_IDLE) ? elapsed_time : t_reg;

    always_comb
    begin
        unique case (state_reg) inside
            ST_IDLE, ST_ACCY:
            begin
                mul_a = signed'({speed_sel[15], speed_sel});
                mul_b = signed'({1'b0, time_sel});
            end
            default:
            begin
                mul_a = signed'({8'b0, len_sel});
                mul_b = sine_val;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
    end

    // step is bits 31:16 of the signed Q32 product
    assign ph_new     = phase_reg[arm_idx_reg] + prod_reg[31:16];
    assign sine_phase = (state_reg == ST_PHASE) ? ph_new
                                                : phase_reg[arm_idx_reg] + QUARTER_TURN;

    racp_sine #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine (
        .clk   (clk),
        .phase (sine_phase),
        .sine  (sine_val)
    );

    // floor((v + 2^14) / 2^15), taken mod 2^13
    assign round_x = acc_x_reg + 28'sd16384;
    assign round_y = acc_y_reg + 28'sd16384;

    always_comb
    begin
        state_next     = state_reg;
        arm_idx_next   = arm_idx_reg;
        t_next         = t_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        out_valid_next = out_valid_reg && out_stall;
        pen_x_next     = pen_x_reg;
        pen_y_next     = pen_y_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    t_next       = elapsed_time;
                    arm_idx_next = '0;
                    acc_x_next   = '0;
                    acc_y_next   = '0;
                    state_next   = ST_PHASE;
                end
            end
            ST_PHASE:
            begin
                state_next = ST_COS;
            end
            ST_COS:
            begin
                state_next = ST_ACCX;
            end
            ST_ACCX:
            begin
                acc_x_next = acc_x_reg + 28'(prod_reg);
                state_next = ST_ACCY;
            end
            ST_ACCY:
            begin
                acc_y_next = acc_y_reg + 28'(prod_reg);
                if (last_arm)
                    state_next = ST_FIN;
                else
                begin
                    arm_idx_next = arm_idx_reg + ARM_W'(1);
                    state_next   = ST_PHASE;
                end
            end
            ST_FIN:
            begin
                // wait for the output register to drain
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    pen_x_next     = 13'(center_x_reg) + round_x[27:15];
                    pen_y_next     = 13'(center_y_reg) - round_y[27:15];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            arm_idx_reg   <= '0;
            t_reg         <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            out_valid_reg <= 1'b0;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            arm_idx_reg   <= arm_idx_next;
            t_reg         <= t_next;
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            out_valid_reg <= out_valid_next;
            pen_x_reg     <= pen_x_next;
            pen_y_reg     <= pen_y_next;
        end
    end

    // phase accumulators; arms out of use are never written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ARMS; i++)
                phase_reg[i] <= '0;
        end
        else if (state_reg == ST_PHASE)
        begin
            phase_reg[arm_idx_reg] <= ph_new;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arm_count_reg   <= 3'd1;
            center_x_reg    <= 10'd400;
            center_y_reg    <= 10'd400;
            arm_lengths_reg <= '0;
            arm_speeds_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ARM_COUNT:   arm_count_reg   <= cfg_data[2:0];
                REG_CENTER_X:    center_x_reg    <= cfg_data[9:0];
                REG_CENTER_Y:    center_y_reg    <= cfg_data[9:0];
                REG_ARM_LENGTHS: arm_lengths_reg <= cfg_data[35:0];
                REG_ARM_SPEEDS:  arm_speeds_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign pen_x     = signed'(pen_x_reg);
    assign pen_y     = signed'(pen_y_reg);

    `RACP_ASSERT_NXT(a_accept_starts, clk, rst_n, in_valid && !in_stall,
        state_reg == ST_PHASE, "accepted transfer did not start the arm sequence")
    `RACP_ASSERT_IMP(a_result_from_fin, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg) == ST_FIN, "result raised outside the finish step")
    `RACP_ASSERT_NXT(a_fin_waits, clk, rst_n, state_reg == ST_FIN && out_valid_reg && out_stall,
        state_reg == ST_FIN && out_valid_reg, "finish step overwrote a waiting result")

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps

// Bench for the rotating arm chain plotter.
// A short directed plan is walked first, then eleven random phases, each with a
// fresh set of registers. Every accepted tick transfer runs through a local model
// of the chain. The model holds its own phase accumulators, registers and
// quarter-wave sine table. It queues the expected pen position, and each pen
// transfer is checked against the oldest entry in that queue.
module tb_top;
    import racp_pkg::*;

    localparam int ARM_SLOTS    = 4;
    localparam int SINE_DEPTH   = 256;
    localparam int PLOT_PHASES  = 11;
    localparam int TICKS_PER_PHASE = 50;
    // A tick passes through the block's arm sequence, with drawn idle waits on
    // each side. The head of the block names no clearing pass after reset, so
    // STALL_LIMIT quiet cycles is far beyond any correct run.
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 40;
    // pi/2 in Q30, used to build the quarter-wave table
    localparam longint unsigned RIGHT_ANGLE_Q30 = 64'd1686629713;

    // indexes the block decodes as nothing at all
    localparam reg_index_t REG_SPARE_A = 3'd5;
    localparam reg_index_t REG_SPARE_B = 3'd6;
    localparam reg_index_t REG_SPARE_C = 3'd7;

    typedef struct packed {
        logic signed [12:0] x;
        logic signed [12:0] y;
    } pen_t;

    // what the sender knows about a tick: a pinned position overrides the model
    typedef struct packed {
        logic pinned;
        pen_t pen;
    } note_t;

    typedef struct packed {
        logic        is_write;
        reg_index_t  index;
        logic [63:0] data;
        logic [15:0] t;
        logic        pinned;
        pen_t        pen;
    } step_t;

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               cfg_write    = 1'b0;
    logic [2:0]         cfg_index    = '0;
    logic [63:0]        cfg_data     = '0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic [15:0]        elapsed_time = '0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic signed [12:0] pen_x;
    logic signed [12:0] pen_y;

    rotating_arm_chain_plotter #(
        .ARMS             (ARM_SLOTS),
        .SINE_TABLE_DEPTH (SINE_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .elapsed_time (elapsed_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pen_x        (pen_x),
        .pen_y        (pen_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // Local copy of the chain: registers as the block should hold them
    // ---------------------------------------------------------------------
    logic [2:0]  chain_count  = 3'd1;
    logic [9:0]  pivot_x      = 10'd400;
    logic [9:0]  pivot_y      = 10'd400;
    logic [35:0] link_lengths = '0;
    logic [63:0] link_speeds  = '0;
    phase_t      link_phase [ARM_SLOTS] = '{default: '0};

    int unsigned sine_quarter [0:SINE_DEPTH];

    // Quarter-wave sine in Q15, from a Taylor series to the 15th power in Q30
    // fixed point, rounded half up and clamped at 1.0.
    initial
    begin : build_sine
        longint unsigned ang;
        longint unsigned term;
        longint unsigned v;
        longint          acc;
        for (int k = 0; k <= SINE_DEPTH; k++)
        begin
            ang  = (RIGHT_ANGLE_Q30 * k) / SINE_DEPTH;
            term = ang;
            acc  = longint'(ang);
            for (int n = 1; n <= 7; n++)
            begin
                term = (term * ang) >> 30;
                term = (term * ang) >> 30;
                term = term / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    acc -= longint'(term);
                else
                    acc += longint'(term);
            end
            if (acc < 0)
                acc = 0;
            v = ($unsigned(acc) + 64'd16384) >> 15;
            if (v > 64'd32768)
                v = 64'd32768;
            sine_quarter[k] = v[31:0];
        end
    end

    // Top two phase bits pick the quadrant, the low 14 bits index the table.
    function automatic longint sine_of(input phase_t ph);
        int unsigned idx;
        longint      mag;
        idx = (int'(ph[13:0]) * SINE_DEPTH) / 16384;
        if (ph[14])
            idx = SINE_DEPTH - idx;
        mag = sine_quarter[idx];
        return ph[15] ? -mag : mag;
    endfunction

    // Advance every active arm by one tick and return where the pen lands.
    function automatic pen_t advance_chain(input logic [15:0] t);
        int          active;
        longint      dx;
        longint      dy;
        longint      spd;
        longint      len;
        longint      px;
        longint      py;
        logic [63:0] prod;
        phase_t      ph;
        pen_t        pen;
        active = chain_count;
        if (active < 1)
            active = 1;
        if (active > ARM_SLOTS)
            active = ARM_SLOTS;
        dx = 0;
        dy = 0;
        for (int i = 0; i < active; i++)
        begin
            spd  = $signed(link_speeds[16*i +: 16]);
            prod = spd * longint'({48'd0, t});
            ph   = link_phase[i] + prod[31:16];
            link_phase[i] = ph;
            len  = link_lengths[9*i +: 9];
            dx  += len * sine_of(ph);
            dy  += len * sine_of(ph + QUARTER_TURN);
        end
        // one rounding per axis, half up, floor via arithmetic shift
        px = longint'(pivot_x) + ((dx + 16384) >>> 15);
        py = longint'(pivot_y) - ((dy + 16384) >>> 15);
        pen.x = px[12:0];
        pen.y = py[12:0];
        return pen;
    endfunction

    // ---------------------------------------------------------------------
    // Scoreboard
    // ---------------------------------------------------------------------
    pen_t  pen_due [$];
    note_t tick_notes [$];
    int    mismatches   = 0;
    int    pens_seen    = 0;
    int    idle_cycles  = 0;
    bit    calm         = 1'b0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH: %s", what);
        mismatches++;
    endtask

    // Both ports are sampled at the rising edge, before the block's own
    // updates land, so each transfer is seen exactly once.
    always @(posedge clk)
    begin : watch_ports
        note_t note;
        pen_t  due;
        bit    moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                note  = tick_notes.pop_front();
                due   = advance_chain(elapsed_time);
                pen_due.push_back(note.pinned ? note.pen : due);
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                pens_seen++;
                if (pen_due.size() == 0)
                    report_mismatch($sformatf("pen %0d (%0d,%0d) with no tick behind it",
                                              pens_seen, pen_x, pen_y));
                else
                begin
                    due = pen_due.pop_front();
                    if (pen_x !== due.x || pen_y !== due.y)
                        report_mismatch($sformatf("pen %0d got (%0d,%0d), want (%0d,%0d)",
                                                  pens_seen, pen_x, pen_y, due.x, due.y));
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    initial
    begin : watchdog
        @(posedge rst_n);
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Pacing: both sides draw a fresh wait per transfer; calm phases run flat out
    // ---------------------------------------------------------------------
    function automatic int draw_wait();
        return calm ? 0 : int'($urandom_range(0, 6));
    endfunction

    // Receiver: stall for a drawn number of cycles, then take one pen.
    initial
    begin : drain_pens
        int hold;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = draw_wait();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // Entered and left at a falling edge. Valid stays high on return so a
    // back-to-back tick keeps the line up; settle drops it when the run pauses.
    task automatic send_tick(input logic [15:0] t, input logic pinned, input pen_t pen);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_notes.push_back({pinned, pen});
        in_valid     <= 1'b1;
        elapsed_time <= t;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Registers only change with the block idle: every pen home.
    task automatic settle();
        in_valid <= 1'b0;
        while (pen_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input reg_index_t index, input logic [63:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        case (index)
            REG_ARM_COUNT:   chain_count  = data[2:0];
            REG_CENTER_X:    pivot_x      = data[9:0];
            REG_CENTER_Y:    pivot_y      = data[9:0];
            REG_ARM_LENGTHS: link_lengths = data[35:0];
            REG_ARM_SPEEDS:  link_speeds  = data;
            default:         ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Directed plan
    // ---------------------------------------------------------------------
    step_t plan [$];

    function automatic void add_write(input reg_index_t index, input logic [63:0] data);
        step_t s;
        s          = '0;
        s.is_write = 1'b1;
        s.index    = index;
        s.data     = data;
        plan.push_back(s);
    endfunction

    function automatic void add_tick(input logic [15:0] t);
        step_t s;
        s   = '0;
        s.t = t;
        plan.push_back(s);
    endfunction

    function automatic void add_pinned(input logic [15:0] t, input logic signed [12:0] x,
                                       input logic signed [12:0] y);
        step_t s;
        s        = '0;
        s.t      = t;
        s.pinned = 1'b1;
        s.pen.x  = x;
        s.pen.y  = y;
        plan.push_back(s);
    endfunction

    initial
    begin : stimulus
        logic [63:0] r;
        logic [63:0] word;
        logic [15:0] lane;
        logic [15:0] t;
        logic [9:0]  centre;
        int          cnt;
        int          tmode;
        int          smode;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // straight out of reset: no length on any arm, pen sits on the pivot
        add_pinned(16'h0000, 13'sd400, 13'sd400);
        add_pinned(16'hFFFF, 13'sd400, 13'sd400);
        // pivot at both ends of its range; junk above the field must be dropped
        add_write(REG_CENTER_X, 64'hFFFF_FFFF_FFFF_FC00);
        add_write(REG_CENTER_Y, 64'hFFFF_FFFF_FFFF_FC00);
        add_pinned(16'h0000, 13'sd0, 13'sd0);
        add_write(REG_CENTER_X, 64'h3FF);
        add_write(REG_CENTER_Y, 64'h3FF);
        add_pinned(16'h1234, 13'sd1023, 13'sd1023);
        // one full-length arm, still pointing up
        add_write(REG_ARM_LENGTHS, 64'hFFFF_FFF0_0000_01FF);
        add_pinned(16'h0000, 13'sd1023, 13'sd512);
        // all four arms at full length straight up: the far end of the y range
        add_write(REG_ARM_COUNT, 64'hFFFF_FFFF_FFFF_FFFC);
        add_write(REG_ARM_LENGTHS, 64'hF_FFFF_FFFF);
        add_write(REG_CENTER_X, 64'h0);
        add_write(REG_CENTER_Y, 64'h0);
        add_pinned(16'h0000, 13'sd0, -13'sd2044);
        // writes past the last register must not disturb anything
        add_write(REG_SPARE_A, '1);
        add_write(REG_SPARE_B, '1);
        add_write(REG_SPARE_C, '1);
        add_pinned(16'h0000, 13'sd0, -13'sd2044);
        // speed extremes, both signs; zero elapsed time holds the phases
        add_write(REG_ARM_SPEEDS, {16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF});
        add_write(REG_CENTER_X, 64'd512);
        add_write(REG_CENTER_Y, 64'd512);
        add_tick(16'hFFFF);
        add_tick(16'h8000);
        add_tick(16'h0000);
        add_tick(16'h0001);
        // count of zero behaves as one arm
        add_write(REG_ARM_COUNT, 64'd0);
        add_tick(16'hFFFF);
        add_tick(16'h7FFF);
        // count above the arm total is clipped
        add_write(REG_ARM_COUNT, 64'd7);
        add_tick(16'hFFFF);
        // idle arms hold their phase, then pick up where they stopped
        add_write(REG_ARM_COUNT, 64'd2);
        add_tick(16'hC000);
        add_tick(16'h0001);
        add_write(REG_ARM_COUNT, 64'd4);
        add_tick(16'hFFFF);
        add_write(REG_ARM_LENGTHS, {9'd0, 9'd341, 9'd170, 9'd511});
        add_write(REG_ARM_SPEEDS, {16'h4000, 16'hC000, 16'h2000, 16'hE000});
        add_write(REG_ARM_COUNT, 64'd3);
        add_tick(16'h4000);
        add_tick(16'h8000);
        add_tick(16'hAAAA);
        add_tick(16'h5555);

        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                settle();
                write_reg(plan[i].index, plan[i].data);
            end
            else
                send_tick(plan[i].t, plan[i].pinned, plan[i].pen);
        end

        // Random phases: fresh registers each time, extremes mixed in,
        // junk in the unused upper bits of every write.
        for (int phase_no = 0; phase_no < PLOT_PHASES; phase_no++)
        begin
            settle();
            calm = ($urandom_range(0, 3) == 0);

            cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
            r = {$urandom, $urandom};
            write_reg(REG_ARM_COUNT, {r[63:3], 3'(cnt)});

            r = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0:       centre = 10'd0;
                1:       centre = 10'h3FF;
                default: centre = r[9:0];
            endcase
            write_reg(REG_CENTER_X, {r[63:10], centre});
            r = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0:       centre = 10'd0;
                1:       centre = 10'h3FF;
                default: centre = r[9:0];
            endcase
            write_reg(REG_CENTER_Y, {r[63:10], centre});

            r = {$urandom, $urandom};
            word = r;
            case ($urandom_range(0, 3))
                0: word[35:0] = '1;
                1:
                begin
                    for (int a = 0; a < ARM_SLOTS; a++)
                        word[9*a +: 9] = 9'($urandom_range(0, 31));
                end
                default: ;
            endcase
            write_reg(REG_ARM_LENGTHS, word);

            // slow spins keep the pen near one spot, extremes test the wrap
            smode = $urandom_range(0, 3);
            word  = {$urandom, $urandom};
            for (int a = 0; a < ARM_SLOTS; a++)
            begin
                lane = word[16*a +: 16];
                if (smode == 0)
                    lane = 16'($urandom_range(0, 511)) - 16'd256;
                else if (smode == 1)
                begin
                    case ($urandom_range(0, 4))
                        0:       lane = 16'h8000;
                        1:       lane = 16'h7FFF;
                        2:       lane = 16'h0000;
                        3:       lane = 16'hFFFF;
                        default: lane = 16'h0001;
                    endcase
                end
                word[16*a +: 16] = lane;
            end
            write_reg(REG_ARM_SPEEDS, word);

            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       write_reg(REG_SPARE_A, {$urandom, $urandom});
                    1:       write_reg(REG_SPARE_B, {$urandom, $urandom});
                    default: write_reg(REG_SPARE_C, {$urandom, $urandom});
                endcase
            end

            tmode = $urandom_range(0, 2);
            for (int k = 0; k < TICKS_PER_PHASE; k++)
            begin
                t = 16'($urandom);
                if (tmode == 1)
                    t = 16'($urandom_range(0, 255));
                else if (tmode == 2 && $urandom_range(0, 3) == 0)
                    t = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                send_tick(t, 1'b0, '0);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/racp_pkg.sv
sv/racp_sine.sv
sv/rotating_arm_chain_plotter.sv
bench/tb_top.sv
